// File: rtl/css_pkg.sv
// Shared types and character codes for the comment and space stripper.
package css_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int unsigned MAX_OUT = 3;

  typedef enum logic [6:0] {
    MODE_NORMAL  = 7'b0000001,
    MODE_SPACE   = 7'b0000010,
    MODE_SLASH   = 7'b0000100,
    MODE_NL      = 7'b0001000,
    MODE_LINE    = 7'b0010000,
    MODE_BLK     = 7'b0100000,
    MODE_BLKSTAR = 7'b1000000
  } mode_t;

  // One request: up to three output bytes, slot 0 goes out first.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] chars;
    logic [1:0]              cnt;
  } req_t;

  function automatic req_t put(input req_t r, input logic [7:0] ch);
    req_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.chars[r.cnt] = ch;
      o.cnt          = r.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage

// File: rtl/comment_and_space_stripper_unit.sv
// Top level of the comment and space stripper.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata[7:0]=in_char, in_tlast=stream_end
//  out_    | out | out_tvalid/tready  | out_tdata[7:0]=out_char, out_tlast=run_last
//
// The front end takes one byte per cycle while the request FIFO has room; each
// pushed request holds the 1 to 3 bytes one input causes. The back end drives one
// byte per cycle while the receiver is ready, so an input that yields k bytes takes
// k output transfers (at most 3) after passing the FIFO and the current-request
// register. Synchronous active-low reset returns the mode to normal and empties the
// FIFO. Either side may stall; the FIFO lets input flow while the output waits.
module comment_and_space_stripper_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast
);

  logic          push, push_ready, pop, pop_valid;
  css_pkg::req_t push_req, pop_req;

  css_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready)
  );

  css_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_req    (pop_req)
  );

  css_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_req    (pop_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/css_front.sv
// Front end: accepts source bytes, tracks comment/space mode, builds output requests.
module css_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  output logic               push,
  output css_pkg::req_t      push_req,
  input  logic               push_ready
);

  css_pkg::mode_t mode_r, mode_nxt;
  css_pkg::req_t  req;
  logic           plain_en;
  logic           acc;

  assign in_tready = push_ready;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc && (req.cnt != 2'd0);
  assign push_req  = req;

  always_comb begin
    req      = '0;
    mode_nxt = mode_r;
    plain_en = 1'b0;
    unique case (mode_r)
      css_pkg::MODE_LINE: begin
        if (in_tdata == css_pkg::CH_NL) mode_nxt = css_pkg::MODE_NORMAL;
      end
      css_pkg::MODE_BLK: begin
        if (in_tdata == css_pkg::CH_STAR) mode_nxt = css_pkg::MODE_BLKSTAR;
      end
      css_pkg::MODE_BLKSTAR: begin
        if (in_tdata == css_pkg::CH_SLASH) mode_nxt = css_pkg::MODE_NORMAL;
        else if (in_tdata != css_pkg::CH_STAR) mode_nxt = css_pkg::MODE_BLK;
      end
      css_pkg::MODE_SLASH: begin
        if (in_tdata == css_pkg::CH_SLASH) begin
          mode_nxt = css_pkg::MODE_LINE;
        end else if (in_tdata == css_pkg::CH_STAR) begin
          mode_nxt = css_pkg::MODE_BLKSTAR;
        end else begin
          req      = css_pkg::put(req, css_pkg::CH_SLASH);
          plain_en = 1'b1;
        end
      end
      css_pkg::MODE_NL: begin
        if (in_tdata != css_pkg::CH_NL) begin
          req      = css_pkg::put(req, css_pkg::CH_NL);
          req      = css_pkg::put(req, css_pkg::CH_TAB);
          plain_en = 1'b1;
        end
      end
      css_pkg::MODE_SPACE: begin
        if (in_tdata != css_pkg::CH_SPACE) plain_en = 1'b1;
      end
      css_pkg::MODE_NORMAL: begin
        plain_en = 1'b1;
      end
      default: begin
        mode_nxt = css_pkg::MODE_NORMAL;
      end
    endcase

    if (plain_en) begin
      if (in_tdata == css_pkg::CH_SLASH) begin
        mode_nxt = css_pkg::MODE_SLASH;
      end else if (in_tdata == css_pkg::CH_SPACE) begin
        req      = css_pkg::put(req, css_pkg::CH_SPACE);
        mode_nxt = css_pkg::MODE_SPACE;
      end else if (in_tdata == css_pkg::CH_TAB) begin
        mode_nxt = css_pkg::MODE_NORMAL;
      end else if (in_tdata == css_pkg::CH_NL) begin
        mode_nxt = css_pkg::MODE_NL;
      end else begin
        req      = css_pkg::put(req, in_tdata);
        mode_nxt = css_pkg::MODE_NORMAL;
      end
    end

    // stream end flushes whatever is held
    if (in_tlast) begin
      if (mode_nxt == css_pkg::MODE_SLASH) begin
        req = css_pkg::put(req, css_pkg::CH_SLASH);
      end else if (mode_nxt == css_pkg::MODE_NL) begin
        req = css_pkg::put(req, css_pkg::CH_NL);
        req = css_pkg::put(req, css_pkg::CH_TAB);
      end
      mode_nxt = css_pkg::MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= css_pkg::MODE_NORMAL;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: rtl/css_queue.sv
// Small request FIFO between front and back ends.
module css_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  css_pkg::req_t push_req,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output css_pkg::req_t pop_req
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  css_pkg::req_t     mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_req    = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_req;
  end

endmodule

// File: rtl/css_back.sv
// Back end: serializes queued requests, one byte per cycle while out_tready is high.
module css_back (
  input  logic          clk,
  input  logic          rst_n,
  output logic          pop,
  input  logic          pop_valid,
  input  css_pkg::req_t pop_req,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  css_pkg::req_t cur_r;
  logic          vld_r, vld_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          last_slot, load, acc;

  assign last_slot  = (pos_r == cur_r.cnt - 2'd1);
  assign acc        = vld_r && out_tready;
  assign load       = !vld_r || (acc && last_slot);
  assign pop        = load && pop_valid;
  assign out_tvalid = vld_r;
  assign out_tdata  = cur_r.chars[pos_r];
  assign out_tlast  = last_slot;

  always_comb begin
    vld_nxt = vld_r;
    pos_nxt = pos_r;
    if (load) begin
      vld_nxt = pop_valid;
      pos_nxt = 2'd0;
    end else if (acc) begin
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_req;
  end

endmodule

// File: rtl/css_checker.sv
// Port-level checks for the comment and space stripper, bound to the top level.
module css_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown({in_tdata, in_tlast}))
    else $error("input request accepted with unknown bits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_nl_then_tab: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == css_pkg::CH_NL |-> !out_tlast)
    else $error("newline ended a request without its tab");

  a_nl_tab_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == css_pkg::CH_NL
      |=> out_tvalid && out_tdata == css_pkg::CH_TAB)
    else $error("newline not followed by tab");

endmodule

bind comment_and_space_stripper_unit css_checker u_css_checker (.*);

// File: test/css_stream_checker.sv
// Checker for the comment and space stripper: predicts cleaned bytes and compares them.
`timescale 1ns / 100ps

module css_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_char
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending,
  output int         bytes_checked
);

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } clean_byte_t;

  css_pkg::mode_t strip_mode;
  logic [7:0]     step_bytes[$];
  clean_byte_t    clean_q[$];
  clean_byte_t    oldest;

  initial begin
    fail_count    = 0;
    pending       = 0;
    bytes_checked = 0;
    strip_mode    = css_pkg::MODE_NORMAL;
  end

  task automatic emit(input logic [7:0] ch);
    if (step_bytes.size() < css_pkg::MAX_OUT) step_bytes.push_back(ch);
  endtask

  task automatic take_plain(input logic [7:0] c);
    case (c)
      css_pkg::CH_SLASH: strip_mode = css_pkg::MODE_SLASH;
      css_pkg::CH_SPACE: begin
        emit(css_pkg::CH_SPACE);
        strip_mode = css_pkg::MODE_SPACE;
      end
      css_pkg::CH_TAB:   strip_mode = css_pkg::MODE_NORMAL;
      css_pkg::CH_NL:    strip_mode = css_pkg::MODE_NL;
      default: begin
        emit(c);
        strip_mode = css_pkg::MODE_NORMAL;
      end
    endcase
  endtask

  task automatic predict_clean(input logic [7:0] c, input logic eos);
    step_bytes.delete();
    case (strip_mode)
      css_pkg::MODE_LINE: begin
        if (c == css_pkg::CH_NL) strip_mode = css_pkg::MODE_NORMAL;
      end
      css_pkg::MODE_BLK: begin
        if (c == css_pkg::CH_STAR) strip_mode = css_pkg::MODE_BLKSTAR;
      end
      css_pkg::MODE_BLKSTAR: begin
        if (c == css_pkg::CH_SLASH) strip_mode = css_pkg::MODE_NORMAL;
        else if (c != css_pkg::CH_STAR) strip_mode = css_pkg::MODE_BLK;
      end
      css_pkg::MODE_SLASH: begin
        if (c == css_pkg::CH_SLASH) begin
          strip_mode = css_pkg::MODE_LINE;
        end else if (c == css_pkg::CH_STAR) begin
          strip_mode = css_pkg::MODE_BLKSTAR;
        end else begin
          emit(css_pkg::CH_SLASH);
          take_plain(c);
        end
      end
      css_pkg::MODE_NL: begin
        if (c != css_pkg::CH_NL) begin
          emit(css_pkg::CH_NL);
          emit(css_pkg::CH_TAB);
          take_plain(c);
        end
      end
      css_pkg::MODE_SPACE: begin
        if (c != css_pkg::CH_SPACE) take_plain(c);
      end
      default: take_plain(c);
    endcase
    if (eos) begin
      if (strip_mode == css_pkg::MODE_SLASH) begin
        emit(css_pkg::CH_SLASH);
      end else if (strip_mode == css_pkg::MODE_NL) begin
        emit(css_pkg::CH_NL);
        emit(css_pkg::CH_TAB);
      end
      strip_mode = css_pkg::MODE_NORMAL;
    end
    foreach (step_bytes[i])
      clean_q.push_back('{out_char: step_bytes[i], run_last: (i == step_bytes.size() - 1)});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      strip_mode = css_pkg::MODE_NORMAL;
      clean_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_clean(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (clean_q.size() == 0) begin
          $error("unexpected output byte %h, nothing pending", out_tdata);
          fail_count++;
        end else begin
          oldest = clean_q.pop_front();
          bytes_checked++;
          if (out_tdata !== oldest.out_char) begin
            $error("out_char expected %h actual %h", oldest.out_char, out_tdata);
            fail_count++;
          end
          if (out_tlast !== oldest.run_last) begin
            $error("run_last expected %b actual %b", oldest.run_last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = clean_q.size();
  end

endmodule

// File: test/comment_and_space_stripper_unit_test.sv
// Testbench top for the comment and space stripper: stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module comment_and_space_stripper_unit_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 300;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [7:0] code;
    logic       eos;
  } src_char_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_char
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_char
  logic       out_tlast;

  int fail_count;
  int pending;
  int bytes_checked;

  src_char_t src_q[$];
  int        live_chars;
  bit        in_comment;
  int        sent_count;
  int        stream_ends;
  int        cycle_count;
  int        hold_left;
  bit        hold_done;

  comment_and_space_stripper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  css_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, and a window without random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (cycle_count >= 300 && cycle_count < 700) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 29);
    end
  end

  task automatic push_char(input logic [7:0] c, input logic eos = 1'b0);
    src_q.push_back('{code: c, eos: eos});
    if (!in_comment) live_chars++;
  endtask

  task automatic push_text(input string s, input logic eos_at_end = 1'b0);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], eos_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == css_pkg::CH_SLASH);
    return c;
  endfunction

  task automatic add_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) push_char(text_char());
    end else if (pick < 34) begin
      n = $urandom_range(1, 4);
      repeat (n) push_char(($urandom_range(3) == 0) ? css_pkg::CH_TAB : css_pkg::CH_SPACE);
    end else if (pick < 46) begin
      n = $urandom_range(1, 3);
      repeat (n) push_char(css_pkg::CH_NL);
      if ($urandom_range(2) == 0) push_char(css_pkg::CH_TAB);
    end else if (pick < 55) begin
      push_char(css_pkg::CH_SLASH);
      push_char(css_pkg::CH_SLASH);
      in_comment = 1'b1;
      n = $urandom_range(0, 5);
      repeat (n) push_char(8'($urandom_range(11, 255)));
      in_comment = 1'b0;
      push_char(css_pkg::CH_NL);
    end else if (pick < 66) begin
      push_char(css_pkg::CH_SLASH);
      push_char(css_pkg::CH_STAR);
      if ($urandom_range(3) == 0) begin
        push_char(css_pkg::CH_SLASH);
      end else begin
        in_comment = 1'b1;
        n = $urandom_range(0, 5);
        repeat (n)
          push_char(($urandom_range(2) == 0) ? css_pkg::CH_STAR : 8'($urandom_range(0, 255)));
        in_comment = 1'b0;
        push_char(css_pkg::CH_STAR);
        push_char(css_pkg::CH_SLASH);
      end
    end else if (pick < 73) begin
      push_char(css_pkg::CH_SLASH);
      push_char(($urandom_range(3) == 0) ? css_pkg::CH_NL : text_char());
    end else if (pick < 86) begin
      n = $urandom_range(1, 4);
      repeat (n) push_char(8'($urandom_range(0, 255)));
    end else if (pick < 89) begin
      // broken block comment, swallows text until a closer shows up
      push_char(css_pkg::CH_SLASH);
      push_char(css_pkg::CH_STAR);
      push_char(text_char());
    end else begin
      case ($urandom_range(4))
        0: push_char(css_pkg::CH_SLASH, 1'b1);
        1: push_char(css_pkg::CH_NL, 1'b1);
        2: push_char(css_pkg::CH_SPACE, 1'b1);
        3: push_char(css_pkg::CH_STAR, 1'b1);
        default: push_char(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  task automatic send_request(input src_char_t item, input bit no_gaps);
    if (!no_gaps && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item.code;
    in_tlast  <= item.eos;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    sent_count++;
    if (item.eos) stream_ends++;
  endtask

  initial begin
    // directed requests
    push_char(8'h61);
    push_char(8'h00);
    push_char(8'hFF);
    push_text("  \t ");
    push_text("\n\n\t");
    push_text("\n//\n");
    push_text("/b");
    push_text("/*/");
    push_char(css_pkg::CH_SLASH, 1'b1);
    push_char(css_pkg::CH_NL, 1'b1);
    push_text("/*z", 1'b1);
    push_text("\n/", 1'b1);
    live_chars = 0;
    while (live_chars < RANDOM_CHARS) add_token();
    src_q[src_q.size() - 1].eos = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (src_q[i]) send_request(src_q[i], (i >= 60 && i < 140));
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d requests (%0d stream ends), checked %0d output bytes",
             sent_count, stream_ends, bytes_checked);
    $display("covered comments, space and newline runs, held slashes, back pressure");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: comment_and_space_stripper_unit.f
rtl/css_pkg.sv
rtl/css_front.sv
rtl/css_queue.sv
rtl/css_back.sv
rtl/comment_and_space_stripper_unit.sv
rtl/css_checker.sv
test/css_stream_checker.sv
test/comment_and_space_stripper_unit_test.sv
